// File: sv/pep_pkg.sv
// ----------------------------------------------------------------------------
// Previous permutation engine package
// Element type and width of the engine; the width also sizes its element memory.
// ----------------------------------------------------------------------------
`default_nettype none

package pep_pkg;

  localparam int ELEM_W = 32;

  typedef logic signed [ELEM_W-1:0] elem_t;

endpackage : pep_pkg

`default_nettype wire

// File: sv/pep_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with a registered read, held when idle.
// ----------------------------------------------------------------------------
`default_nettype none

module pep_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule : pep_ram

`default_nettype wire

// File: sv/previous_permutation_engine_unit.sv
// ----------------------------------------------------------------------------
// Previous permutation engine
// Loads a sequence one item per cycle while not busy and emits its
// lexicographically previous permutation in signed order.
// ----------------------------------------------------------------------------
// Elements are accepted one per cycle while busy is low; the item with
// in_elem_last set ends the sequence, and elements beyond MAX_LEN are dropped
// and flagged on out_overflow. The engine then raises busy and works on the
// sequence through a simple dual-port element memory and one shared signed
// comparator. For n stored elements, pivot index i and suffix length
// s = n - 1 - i, it reads and compares elements from the end to find the
// pivot, scans the s suffix elements for the swap candidate, writes the swap
// and reverses the suffix pair by pair, then outputs the n elements, one
// element per cycle. Results appear on out_value with out_strobe for exactly
// one cycle each and cannot be held off. The memory contents are not cleared
// after reset, and no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module previous_permutation_engine_unit
  import pep_pkg::*;
#(
  parameter int MAX_LEN = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [ELEM_W-1:0] in_elem_value,
  input  wire logic              in_elem_last,
  output logic                   out_strobe,
  output logic [ELEM_W-1:0]      out_value,
  output logic                   out_last,
  output logic                   out_changed,
  output logic                   out_overflow
);

  localparam int AW = $clog2(MAX_LEN);
  localparam int CW = $clog2(MAX_LEN + 1);

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_P_RD,
    ST_P_CMP,
    ST_B_RD,
    ST_B_CMP,
    ST_B_CMP2,
    ST_SW_I,
    ST_SW_B,
    ST_R_RDLO,
    ST_R_RDHI,
    ST_R_WLO,
    ST_R_WHI,
    ST_EMIT
  } state_t;

  state_t          state_r, state_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            ovf_r, ovf_nxt;
  logic [CW-1:0]   j_r, j_nxt;
  logic [AW-1:0]   piv_r, piv_nxt;
  logic [AW-1:0]   best_r, best_nxt;
  logic [AW-1:0]   lo_r, lo_nxt;
  logic [AW-1:0]   hi_r, hi_nxt;
  elem_t           pv_r, pv_nxt;
  elem_t           bestv_r, bestv_nxt;
  elem_t           cur_r, cur_nxt;
  elem_t           tmp_r, tmp_nxt;
  logic            first_r, first_nxt;
  logic            chg_r, chg_nxt;
  logic            out_strobe_r, out_strobe_nxt;
  logic            out_last_r, out_last_nxt;
  logic            out_changed_r, out_changed_nxt;
  logic            out_overflow_r, out_overflow_nxt;

  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  elem_t           wr_data;
  logic            rd_en;
  logic [AW-1:0]   rd_addr;
  logic [ELEM_W-1:0] rd_raw;
  elem_t           rd_data;

  elem_t           cmp_a, cmp_b;
  logic            cmp_gt;
  logic            full;
  logic [CW-1:0]   n_fin;

  pep_ram #(
    .WIDTH (ELEM_W),
    .DEPTH (MAX_LEN)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_raw)
  );

  assign rd_data = elem_t'(rd_raw);
  assign cmp_gt  = cmp_a > cmp_b;
  assign full    = (cnt_r >= CW'(MAX_LEN));
  assign n_fin   = full ? cnt_r : cnt_r + CW'(1);

  always_comb begin
    state_nxt        = state_r;
    cnt_nxt          = cnt_r;
    ovf_nxt          = ovf_r;
    j_nxt            = j_r;
    piv_nxt          = piv_r;
    best_nxt         = best_r;
    lo_nxt           = lo_r;
    hi_nxt           = hi_r;
    pv_nxt           = pv_r;
    bestv_nxt        = bestv_r;
    cur_nxt          = cur_r;
    tmp_nxt          = tmp_r;
    first_nxt        = first_r;
    chg_nxt          = chg_r;
    out_strobe_nxt   = 1'b0;
    out_last_nxt     = out_last_r;
    out_changed_nxt  = out_changed_r;
    out_overflow_nxt = out_overflow_r;
    wr_en            = 1'b0;
    wr_addr          = cnt_r[AW-1:0];
    wr_data          = elem_t'(in_elem_value);
    rd_en            = 1'b0;
    rd_addr          = j_r[AW-1:0];
    cmp_a            = rd_data;
    cmp_b            = cur_r;

    unique case (state_r)
      ST_LOAD: begin
        if (start) begin
          if (!full) begin
            wr_en   = 1'b1;
            cnt_nxt = cnt_r + CW'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_elem_last) begin
            if (n_fin < CW'(2)) begin
              chg_nxt   = 1'b0;
              j_nxt     = '0;
              state_nxt = ST_EMIT;
            end else begin
              j_nxt     = n_fin - CW'(1);
              first_nxt = 1'b1;
              state_nxt = ST_P_RD;
            end
          end
        end
      end
      ST_P_RD: begin
        rd_en     = 1'b1;
        state_nxt = ST_P_CMP;
      end
      ST_P_CMP: begin
        if (!first_r && cmp_gt) begin
          piv_nxt   = j_r[AW-1:0];
          pv_nxt    = rd_data;
          best_nxt  = AW'(j_r + CW'(1));
          bestv_nxt = cur_r;
          j_nxt     = j_r + CW'(2);
          state_nxt = ST_B_RD;
        end else begin
          cur_nxt   = rd_data;
          first_nxt = 1'b0;
          if (j_r == '0) begin
            chg_nxt   = 1'b0;
            state_nxt = ST_EMIT;
          end else begin
            j_nxt     = j_r - CW'(1);
            state_nxt = ST_P_RD;
          end
        end
      end
      ST_B_RD: begin
        if (j_r >= cnt_r) begin
          state_nxt = ST_SW_I;
        end else begin
          rd_en     = 1'b1;
          state_nxt = ST_B_CMP;
        end
      end
      ST_B_CMP: begin
        cmp_a   = pv_r;
        cmp_b   = rd_data;
        cur_nxt = rd_data;
        if (cmp_gt) begin
          state_nxt = ST_B_CMP2;
        end else begin
          j_nxt     = j_r + CW'(1);
          state_nxt = ST_B_RD;
        end
      end
      ST_B_CMP2: begin
        cmp_a = bestv_r;
        cmp_b = cur_r;
        if (!cmp_gt) begin
          best_nxt  = j_r[AW-1:0];
          bestv_nxt = cur_r;
        end
        j_nxt     = j_r + CW'(1);
        state_nxt = ST_B_RD;
      end
      ST_SW_I: begin
        wr_en     = 1'b1;
        wr_addr   = piv_r;
        wr_data   = bestv_r;
        lo_nxt    = piv_r + AW'(1);
        hi_nxt    = AW'(cnt_r - CW'(1));
        state_nxt = ST_SW_B;
      end
      ST_SW_B: begin
        wr_en     = 1'b1;
        wr_addr   = best_r;
        wr_data   = pv_r;
        state_nxt = ST_R_RDLO;
      end
      ST_R_RDLO: begin
        if (lo_r >= hi_r) begin
          chg_nxt   = 1'b1;
          j_nxt     = '0;
          state_nxt = ST_EMIT;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = lo_r;
          state_nxt = ST_R_RDHI;
        end
      end
      ST_R_RDHI: begin
        tmp_nxt   = rd_data;
        rd_en     = 1'b1;
        rd_addr   = hi_r;
        state_nxt = ST_R_WLO;
      end
      ST_R_WLO: begin
        wr_en     = 1'b1;
        wr_addr   = lo_r;
        wr_data   = rd_data;
        state_nxt = ST_R_WHI;
      end
      ST_R_WHI: begin
        wr_en     = 1'b1;
        wr_addr   = hi_r;
        wr_data   = tmp_r;
        lo_nxt    = lo_r + AW'(1);
        hi_nxt    = hi_r - AW'(1);
        state_nxt = ST_R_RDLO;
      end
      ST_EMIT: begin
        rd_en            = 1'b1;
        out_strobe_nxt   = 1'b1;
        out_last_nxt     = (j_r == cnt_r - CW'(1));
        out_changed_nxt  = chg_r;
        out_overflow_nxt = ovf_r;
        if (j_r == cnt_r - CW'(1)) begin
          cnt_nxt   = '0;
          ovf_nxt   = 1'b0;
          state_nxt = ST_LOAD;
        end else begin
          j_nxt = j_r + CW'(1);
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_LOAD;
      cnt_r          <= '0;
      ovf_r          <= 1'b0;
      out_strobe_r   <= 1'b0;
      first_r        <= 1'b0;
      chg_r          <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      cnt_r          <= cnt_nxt;
      ovf_r          <= ovf_nxt;
      out_strobe_r   <= out_strobe_nxt;
      first_r        <= first_nxt;
      chg_r          <= chg_nxt;
    end
    j_r            <= j_nxt;
    piv_r          <= piv_nxt;
    best_r         <= best_nxt;
    lo_r           <= lo_nxt;
    hi_r           <= hi_nxt;
    pv_r           <= pv_nxt;
    bestv_r        <= bestv_nxt;
    cur_r          <= cur_nxt;
    tmp_r          <= tmp_nxt;
    out_last_r     <= out_last_nxt;
    out_changed_r  <= out_changed_nxt;
    out_overflow_r <= out_overflow_nxt;
  end

  assign busy         = (state_r != ST_LOAD);
  assign out_strobe   = out_strobe_r;
  assign out_value    = rd_raw;
  assign out_last     = out_last_r;
  assign out_changed  = out_changed_r;
  assign out_overflow = out_overflow_r;

endmodule : previous_permutation_engine_unit

`default_nettype wire

// File: sv/pep_checker.sv
// ----------------------------------------------------------------------------
// Previous permutation engine port checker
// Checks how results are sequenced against the command handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module pep_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        in_elem_last,
  input wire logic        out_strobe,
  input wire logic        out_last,
  input wire logic        out_changed,
  input wire logic        out_overflow
);

  // Every result but the final one of a sequence is shown while busy.
  a_busy_during_output: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_last |-> busy)
    else $error("result shown while not busy");

  // A sequence is emitted without gaps until its final result.
  a_output_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_last |=> out_strobe)
    else $error("gap inside an emitted sequence");

  // The flags are the same on every result of one sequence.
  a_flags_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_last |=> $stable(out_changed) && $stable(out_overflow))
    else $error("flags changed within a sequence");

  // An item that does not end a sequence causes no result and leaves busy low right after it.
  a_no_result_midload: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && !in_elem_last |=> !out_strobe && !busy)
    else $error("unexpected result or busy while loading");

endmodule : pep_checker

bind previous_permutation_engine_unit pep_checker u_pep_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .in_elem_last  (in_elem_last),
  .out_strobe    (out_strobe),
  .out_last      (out_last),
  .out_changed   (out_changed),
  .out_overflow  (out_overflow)
);

`default_nettype wire

// File: verif/previous_permutation_engine_unit_tb.sv
// ----------------------------------------------------------------------------
// Previous permutation engine testbench
// Sends element sequences through the command interface, predicts the
// lexicographically previous permutation of each one in signed order, and
// checks every emitted element together with its last, changed and overflow
// flags. Directed sequences come first, followed by random sequences, and all
// elements are sent in bursts with random gaps between them.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module previous_permutation_engine_unit_tb;
  import pep_pkg::*;

  localparam int MAX_LEN = 16;

  typedef struct packed {
    elem_t value;
    logic  last;
    logic  drain;
  } elem_item_t;

  typedef struct packed {
    elem_t value;
    logic  last;
    logic  changed;
    logic  overflow;
  } perm_result_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic [ELEM_W-1:0] in_elem_value = '0;
  logic              in_elem_last = 1'b0;
  logic              busy;
  logic              out_strobe;
  logic [ELEM_W-1:0] out_value;
  logic              out_last;
  logic              out_changed;
  logic              out_overflow;

  elem_item_t   elem_q[$];
  perm_result_t perm_q[$];

  elem_t seq_buf[MAX_LEN];
  int    fill_cnt = 0;
  logic  ovf_seen = 1'b0;

  int accept_cnt = 0;
  int seen_cnt = 0;
  int burst_left = 0;
  int gap_left = 0;
  int err_cnt = 0;

  previous_permutation_engine_unit #(
    .MAX_LEN(MAX_LEN)
  ) DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_elem_value(in_elem_value),
    .in_elem_last (in_elem_last),
    .out_strobe   (out_strobe),
    .out_value    (out_value),
    .out_last     (out_last),
    .out_changed  (out_changed),
    .out_overflow (out_overflow)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Stores one accepted element and, on the final one, predicts the whole
  // rewritten sequence.
  task automatic absorb_element(input elem_t value, input logic last);
    int n;
    int piv;
    int best;
    int lo;
    int hi;
    elem_t tmp;
    logic chg;
    perm_result_t r;
    if (fill_cnt < MAX_LEN) begin
      seq_buf[fill_cnt] = value;
      fill_cnt++;
    end else begin
      ovf_seen = 1'b1;
    end
    if (last) begin
      n = fill_cnt;
      piv = -1;
      chg = 1'b0;
      for (int i = n - 1; i > 0 && piv < 0; i--) begin
        if (seq_buf[i-1] > seq_buf[i]) piv = i - 1;
      end
      if (piv >= 0) begin
        chg = 1'b1;
        best = piv + 1;
        for (int j = piv + 1; j < n; j++) begin
          if (seq_buf[j] < seq_buf[piv] && seq_buf[j] >= seq_buf[best]) best = j;
        end
        tmp = seq_buf[piv];
        seq_buf[piv] = seq_buf[best];
        seq_buf[best] = tmp;
        lo = piv + 1;
        hi = n - 1;
        while (lo < hi) begin
          tmp = seq_buf[lo];
          seq_buf[lo] = seq_buf[hi];
          seq_buf[hi] = tmp;
          lo++;
          hi--;
        end
      end
      for (int k = 0; k < n; k++) begin
        r.value = seq_buf[k];
        r.last = (k == n - 1);
        r.changed = chg;
        r.overflow = ovf_seen;
        perm_q.push_back(r);
      end
      fill_cnt = 0;
      ovf_seen = 1'b0;
    end
  endtask

  task automatic queue_element(input elem_t value, input logic last, input logic drain);
    elem_item_t it;
    it.value = value;
    it.last = last;
    it.drain = drain;
    elem_q.push_back(it);
  endtask

  function automatic elem_t rand_value(input int mode);
    int pick;
    case (mode)
      0: return elem_t'(int'($urandom_range(0, 6)) - 3);
      1: return elem_t'($urandom);
      2: begin
        pick = $urandom_range(0, 4);
        case (pick)
          0: return elem_t'(32'h8000_0000);
          1: return elem_t'(32'h7FFF_FFFF);
          2: return elem_t'(-1);
          3: return elem_t'(0);
          default: return elem_t'(1);
        endcase
      end
      default: return elem_t'(int'($urandom_range(0, 40)) - 20);
    endcase
  endfunction

  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (accept_cnt != seen_cnt) begin
        seen_cnt = accept_cnt;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 12);
          case ($urandom_range(0, 5))
            0, 1: gap_left = 0;
            2, 3: gap_left = $urandom_range(1, 4);
            4: gap_left = $urandom_range(5, 12);
            default: gap_left = $urandom_range(20, 60);
          endcase
        end
      end
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (elem_q.size() > 0 && !(elem_q[0].drain && perm_q.size() > 0)) begin
        start <= 1'b1;
        in_elem_value <= elem_q[0].value;
        in_elem_last <= elem_q[0].last;
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    elem_item_t it;
    perm_result_t want;
    if (rst_n) begin
      if (out_strobe) begin
        if (perm_q.size() == 0) begin
          if (err_cnt < 10) begin
            $display("unexpected result: value=%0d last=%b changed=%b overflow=%b",
                     $signed(out_value), out_last, out_changed, out_overflow);
          end
          err_cnt++;
        end else begin
          want = perm_q.pop_front();
          if (out_value !== want.value || out_last !== want.last ||
              out_changed !== want.changed || out_overflow !== want.overflow) begin
            if (err_cnt < 10) begin
              $display("mismatch: expected value=%0d last=%b changed=%b overflow=%b",
                       want.value, want.last, want.changed, want.overflow);
              $display("          actual   value=%0d last=%b changed=%b overflow=%b",
                       $signed(out_value), out_last, out_changed, out_overflow);
            end
            err_cnt++;
          end
        end
      end
      if (start && !busy) begin
        it = elem_q.pop_front();
        accept_cnt++;
        absorb_element(it.value, it.last);
      end
    end
  end

  initial begin
    int len;
    int mode;
    int seq_idx;
    int sel;

    // Single element, then a two-element swap at the extremes.
    queue_element(elem_t'(32'h8000_0000), 1'b1, 1'b0);
    queue_element(elem_t'(32'h7FFF_FFFF), 1'b0, 1'b0);
    queue_element(elem_t'(32'h8000_0000), 1'b1, 1'b0);
    // Already the first permutation.
    queue_element(elem_t'(-1), 1'b0, 1'b1);
    queue_element(elem_t'(0), 1'b0, 1'b0);
    queue_element(elem_t'(1), 1'b1, 1'b0);
    // Equal candidates below the pivot.
    queue_element(elem_t'(2), 1'b0, 1'b0);
    queue_element(elem_t'(1), 1'b0, 1'b0);
    queue_element(elem_t'(1), 1'b1, 1'b0);
    // One element past the store, and the dropped element ends the sequence.
    for (int k = 0; k <= MAX_LEN; k++) begin
      queue_element(elem_t'(32'h7FFF_FFF0 - k * 32'h1111_1111), k == MAX_LEN, 1'b0);
    end

    seq_idx = 0;
    while (elem_q.size() < 260) begin
      sel = $urandom_range(0, 9);
      if (sel < 6) len = $urandom_range(1, 5);
      else if (sel < 9) len = $urandom_range(6, MAX_LEN);
      else len = $urandom_range(MAX_LEN + 1, MAX_LEN + 4);
      mode = $urandom_range(0, 3);
      for (int k = 0; k < len; k++) begin
        queue_element(rand_value(mode), k == len - 1, k == 0 && seq_idx % 9 == 4);
      end
      seq_idx++;
    end

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (elem_q.size() != 0 || perm_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (err_cnt == 0 && perm_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// File: files.f
sv/pep_pkg.sv
sv/pep_ram.sv
sv/previous_permutation_engine_unit.sv
sv/pep_checker.sv
verif/previous_permutation_engine_unit_tb.sv
